### hw/rtl/ssfb_pkg.sv
`default_nettype none
package ssfb_pkg;

  localparam int VALUE_W      = 10;
  localparam int FIELDS       = 4;
  localparam int ROW_SLOTS    = 16;
  localparam int FRAME_BYTES  = 16;
  localparam int SEGMENT_ROWS = 8;
  localparam int IDX_W        = $clog2(FRAME_BYTES);

  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(FRAME_BYTES - 1);
  localparam logic [7:0]       ADDR_CMD_BASE = 8'hC0;

  localparam logic LAYOUT_THREE = 1'b0;  // four 3-digit fields
  localparam logic LAYOUT_TWO   = 1'b1;  // three 2-digit fields and one 1-digit field

  typedef logic [3:0] bcd_t;
  typedef logic [7:0] seg_t;

  typedef struct packed {
    logic                           layout;
    logic                           chip;
    logic [FIELDS-1:0][VALUE_W-1:0] value;
  } frame_req_t;

  typedef struct packed {
    logic              layout;
    logic              chip;
    bcd_t [FIELDS-1:0] hund;
    bcd_t [FIELDS-1:0] tens;
    bcd_t [FIELDS-1:0] units;
  } digits_t;

  typedef struct packed {
    logic                       chip;
    seg_t [FRAME_BYTES-1:0]     data;
  } frame_t;

  function automatic seg_t digit_glyph(bcd_t d);
    seg_t code;
    unique case (d)
      4'd0: code = 8'hFC;
      4'd1: code = 8'h60;
      4'd2: code = 8'hDA;
      4'd3: code = 8'hF2;
      4'd4: code = 8'h66;
      4'd5: code = 8'hB6;
      4'd6: code = 8'hBE;
      4'd7: code = 8'hE0;
      4'd8: code = 8'hFE;
      4'd9: code = 8'hF6;
      default: code = 8'hFC;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/seven_segment_frame_builder_unit.sv
`default_nettype none
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall  | layout, target_chip, four 10-bit values
// out_    | output    | out_valid / out_stall| chip, address_command, segment_byte, last_of_frame
//
// each item yields 16 results, one per cycle while out_stall is low; the output serializer's
// single result port sets the sustained rate and loads no new item before the last is taken
// first result is registered through the saturate, hundreds, tens/units and segments stages
// synchronous active-low reset clears the stage valid bits and the byte index
// out_stall freezes the current result; up to four further items wait in the stages
// before in_stall rises
module seven_segment_frame_builder_unit #(
  parameter int DIGIT_COLUMNS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_layout,
  input  wire logic        in_target_chip,
  input  wire logic [9:0]  in_first_value,
  input  wire logic [9:0]  in_second_value,
  input  wire logic [9:0]  in_third_value,
  input  wire logic [9:0]  in_fourth_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_chip,
  output logic [7:0]       out_address_command,
  output logic [7:0]       out_segment_byte,
  output logic             out_last_of_frame
);

  ssfb_pkg::frame_req_t  req;
  ssfb_pkg::digits_t     digits;
  ssfb_pkg::frame_t      frame;
  logic                  in_ready;
  logic                  dig_valid, dig_ready;
  logic                  frm_valid, frm_ready;

  assign req.layout   = in_layout;
  assign req.chip     = in_target_chip;
  assign req.value[0] = in_first_value;
  assign req.value[1] = in_second_value;
  assign req.value[2] = in_third_value;
  assign req.value[3] = in_fourth_value;
  assign in_stall     = !in_ready;

  ssfb_decimal u_decimal (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (req),
    .out_valid  (dig_valid),
    .out_ready  (dig_ready),
    .out_digits (digits)
  );

  ssfb_segment #(
    .DIGIT_COLUMNS (DIGIT_COLUMNS)
  ) u_segment (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dig_valid),
    .in_ready  (dig_ready),
    .in_digits (digits),
    .out_valid (frm_valid),
    .out_ready (frm_ready),
    .out_frame (frame)
  );

  ssfb_serializer u_serializer (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (frm_valid),
    .in_ready            (frm_ready),
    .in_frame            (frame),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_chip            (out_chip),
    .out_address_command (out_address_command),
    .out_segment_byte    (out_segment_byte),
    .out_last_of_frame   (out_last_of_frame)
  );

endmodule
`default_nettype wire

### hw/rtl/ssfb_decimal.sv
`default_nettype none
module ssfb_decimal (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssfb_pkg::frame_req_t in_req,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ssfb_pkg::digits_t        out_digits
);

  typedef struct packed {
    logic                                     layout;
    logic                                     chip;
    ssfb_pkg::bcd_t [ssfb_pkg::FIELDS-1:0]    hund;
    logic [ssfb_pkg::FIELDS-1:0][6:0]         rem;
  } split_t;

  logic                  s1_valid_r, s2_valid_r, s3_valid_r;
  logic                  s1_ready, s2_ready, s3_ready;
  ssfb_pkg::frame_req_t  s1_r, s1_nxt;
  split_t                s2_r, s2_nxt;
  ssfb_pkg::digits_t     s3_r, s3_nxt;

  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = !s2_valid_r || s3_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_ready  = s1_ready;
  assign out_valid = s3_valid_r;
  assign out_digits = s3_r;

  // stage 1: saturate each value to its field
  always_comb begin
    logic [ssfb_pkg::VALUE_W-1:0] cap;
    s1_nxt = in_req;
    for (int f = 0; f < ssfb_pkg::FIELDS; f++) begin
      if (in_req.layout == ssfb_pkg::LAYOUT_THREE) begin
        cap = 10'd999;
      end else if (f == ssfb_pkg::FIELDS - 1) begin
        cap = 10'd9;
      end else begin
        cap = 10'd99;
      end
      if (in_req.value[f] > cap) s1_nxt.value[f] = cap;
    end
  end

  // stage 2: hundreds digit by parallel compares
  always_comb begin
    s2_nxt.layout = s1_r.layout;
    s2_nxt.chip   = s1_r.chip;
    for (int f = 0; f < ssfb_pkg::FIELDS; f++) begin
      s2_nxt.hund[f] = '0;
      s2_nxt.rem[f]  = 7'(s1_r.value[f]);
      for (int k = 1; k < 10; k++) begin
        if (s1_r.value[f] >= 10'(k * 100)) begin
          s2_nxt.hund[f] = 4'(k);
          s2_nxt.rem[f]  = 7'(s1_r.value[f] - 10'(k * 100));
        end
      end
    end
  end

  // stage 3: tens and units of the remainder
  always_comb begin
    s3_nxt.layout = s2_r.layout;
    s3_nxt.chip   = s2_r.chip;
    s3_nxt.hund   = s2_r.hund;
    for (int f = 0; f < ssfb_pkg::FIELDS; f++) begin
      s3_nxt.tens[f]  = '0;
      s3_nxt.units[f] = 4'(s2_r.rem[f]);
      for (int k = 1; k < 10; k++) begin
        if (s2_r.rem[f] >= 7'(k * 10)) begin
          s3_nxt.tens[f]  = 4'(k);
          s3_nxt.units[f] = 4'(s2_r.rem[f] - 7'(k * 10));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1_r <= s1_nxt;
    if (s2_ready) s2_r <= s2_nxt;
    if (s3_ready) s3_r <= s3_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/ssfb_segment.sv
`default_nettype none
module ssfb_segment #(
  parameter int DIGIT_COLUMNS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ssfb_pkg::digits_t in_digits,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ssfb_pkg::frame_t     out_frame
);

  logic              valid_r;
  ssfb_pkg::frame_t  frame_r, frame_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_frame = frame_r;

  always_comb begin
    ssfb_pkg::bcd_t row [ssfb_pkg::ROW_SLOTS];
    ssfb_pkg::seg_t code;
    for (int c = 0; c < ssfb_pkg::ROW_SLOTS; c++) row[c] = '0;
    if (in_digits.layout == ssfb_pkg::LAYOUT_THREE) begin
      for (int f = 0; f < ssfb_pkg::FIELDS; f++) begin
        row[3*f]   = in_digits.hund[f];
        row[3*f+1] = in_digits.tens[f];
        row[3*f+2] = in_digits.units[f];
      end
    end else begin
      for (int f = 0; f < ssfb_pkg::FIELDS - 1; f++) begin
        row[2*f]   = in_digits.tens[f];
        row[2*f+1] = in_digits.units[f];
      end
      row[2*(ssfb_pkg::FIELDS-1)] = in_digits.units[ssfb_pkg::FIELDS-1];
    end

    frame_nxt.chip = in_digits.chip;
    frame_nxt.data = '0;
    // transpose: byte 2r gets bit 7-r of columns 0..7, byte 2r+1 of columns 8..15
    for (int c = 0; c < ssfb_pkg::ROW_SLOTS; c++) begin
      code = (c < DIGIT_COLUMNS) ? ssfb_pkg::digit_glyph(row[c]) : '0;
      for (int r = 0; r < ssfb_pkg::SEGMENT_ROWS; r++) begin
        if (c < 8) begin
          frame_nxt.data[2*r][c] = code[7-r];
        end else begin
          frame_nxt.data[2*r+1][c-8] = code[7-r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) frame_r <= frame_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/ssfb_serializer.sv
`default_nettype none
module ssfb_serializer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ssfb_pkg::frame_t    in_frame,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_chip,
  output logic [7:0]               out_address_command,
  output logic [7:0]               out_segment_byte,
  output logic                     out_last_of_frame
);

  logic                          valid_r, valid_nxt;
  logic [ssfb_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  ssfb_pkg::frame_t              frame_r;
  logic                          load, take, at_last;

  assign at_last  = idx_r == ssfb_pkg::LAST_IDX;
  assign take     = valid_r && !out_stall;
  assign in_ready = !valid_r || (take && at_last);
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (take) begin
      if (at_last) valid_nxt = 1'b0;
      else         idx_nxt   = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) frame_r <= in_frame;
  end

  assign out_valid           = valid_r;
  assign out_chip            = frame_r.chip;
  assign out_address_command = ssfb_pkg::ADDR_CMD_BASE + 8'(idx_r);
  assign out_segment_byte    = frame_r.data[idx_r];
  assign out_last_of_frame   = at_last;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (valid_r && idx_r == $past(idx_r)))
    else $error("byte index moved while stalled");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_stall && !at_last) |=>
      (valid_r && idx_r == ssfb_pkg::IDX_W'($past(idx_r) + 1'b1)))
    else $error("byte index did not step by one");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_stall && at_last && !in_valid) |=> !valid_r)
    else $error("frame did not end after last byte");

  a_new_frame_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (valid_r && idx_r == '0))
    else $error("new frame did not start at byte zero");

endmodule
`default_nettype wire

### tb/sv/segment_frame_compare.sv
`default_nettype none
module segment_frame_compare #(
  parameter int DIGIT_COLUMNS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic       in_layout,
  input  wire logic       in_target_chip,
  input  wire logic [9:0] in_first_value,
  input  wire logic [9:0] in_second_value,
  input  wire logic [9:0] in_third_value,
  input  wire logic [9:0] in_fourth_value,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic       out_chip,
  input  wire logic [7:0] out_address_command,
  input  wire logic [7:0] out_segment_byte,
  input  wire logic       out_last_of_frame,
  output int              mismatch_count,
  output int              pairs_outstanding
);

  typedef struct packed {
    logic       chip;
    logic [7:0] address_command;
    logic [7:0] segment_byte;
    logic       last_of_frame;
  } byte_pair_t;

  // glyphs for digits 9 down to 0, indexed by the digit
  localparam logic [9:0][7:0] DIGIT_GLYPHS = {
    8'hF6, 8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
  };

  byte_pair_t expected_pairs[$];

  function automatic logic [15:0][7:0] transposed_frame(logic layout,
                                                         logic [3:0][9:0] counts);
    logic [3:0] digit_row [16];
    logic [15:0][7:0] frame_bytes;
    logic [7:0] glyph;
    int pos;
    int ndig;
    int cap;
    int v;
    for (int col = 0; col < 16; col++) digit_row[col] = 4'd0;
    frame_bytes = '0;
    pos = 0;
    for (int f = 0; f < 4; f++) begin
      if (layout == ssfb_pkg::LAYOUT_THREE) ndig = 3;
      else ndig = (f == 3) ? 1 : 2;
      cap = (ndig == 3) ? 999 : (ndig == 2) ? 99 : 9;
      v = (int'(counts[f]) > cap) ? cap : int'(counts[f]);
      for (int k = ndig - 1; k >= 0; k--) begin
        if (pos + k < 16) digit_row[pos + k] = 4'(v % 10);
        v = v / 10;
      end
      pos += ndig;
    end
    for (int r = 0; r < 8; r++) begin
      for (int col = 0; col < 16; col++) begin
        if (col < DIGIT_COLUMNS) begin
          glyph = DIGIT_GLYPHS[digit_row[col]];
          frame_bytes[2 * r + col / 8][col % 8] = glyph[7 - r];
        end
      end
    end
    return frame_bytes;
  endfunction

  always @(posedge clk) begin
    byte_pair_t want;
    logic [15:0][7:0] frame_bytes;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected result: address_command %0h segment_byte %0h",
                 out_address_command, out_segment_byte);
          mismatch_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_chip !== want.chip) begin
            $error("chip: expected %0d, got %0d", want.chip, out_chip);
            mismatch_count++;
          end
          if (out_address_command !== want.address_command) begin
            $error("address_command: expected %0h, got %0h",
                   want.address_command, out_address_command);
            mismatch_count++;
          end
          if (out_segment_byte !== want.segment_byte) begin
            $error("segment_byte: expected %0h, got %0h",
                   want.segment_byte, out_segment_byte);
            mismatch_count++;
          end
          if (out_last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0d, got %0d",
                   want.last_of_frame, out_last_of_frame);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        frame_bytes = transposed_frame(in_layout, {in_fourth_value, in_third_value,
                                                   in_second_value, in_first_value});
        for (int i = 0; i < ssfb_pkg::FRAME_BYTES; i++) begin
          want.chip            = in_target_chip;
          want.address_command = ssfb_pkg::ADDR_CMD_BASE + 8'(i);
          want.segment_byte    = frame_bytes[i];
          want.last_of_frame   = (i == ssfb_pkg::FRAME_BYTES - 1);
          expected_pairs.push_back(want);
        end
      end
    end
    pairs_outstanding = expected_pairs.size();
  end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none
module testbench;

  localparam int COLUMNS = 16;
  localparam int RANDOM_FRAMES = 280;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_layout = ssfb_pkg::LAYOUT_THREE;
  logic       in_target_chip = 1'b0;
  logic [9:0] in_first_value = '0;
  logic [9:0] in_second_value = '0;
  logic [9:0] in_third_value = '0;
  logic [9:0] in_fourth_value = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_chip;
  logic [7:0] out_address_command;
  logic [7:0] out_segment_byte;
  logic       out_last_of_frame;
  int         mismatch_count;
  int         pairs_outstanding;

  int stall_mode = 0;
  int stall_span = 0;

  seven_segment_frame_builder_unit #(.DIGIT_COLUMNS(COLUMNS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_layout(in_layout), .in_target_chip(in_target_chip),
    .in_first_value(in_first_value), .in_second_value(in_second_value),
    .in_third_value(in_third_value), .in_fourth_value(in_fourth_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_chip(out_chip), .out_address_command(out_address_command),
    .out_segment_byte(out_segment_byte), .out_last_of_frame(out_last_of_frame)
  );

  segment_frame_compare #(.DIGIT_COLUMNS(COLUMNS)) frame_compare (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_layout(in_layout), .in_target_chip(in_target_chip),
    .in_first_value(in_first_value), .in_second_value(in_second_value),
    .in_third_value(in_third_value), .in_fourth_value(in_fourth_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_chip(out_chip), .out_address_command(out_address_command),
    .out_segment_byte(out_segment_byte), .out_last_of_frame(out_last_of_frame),
    .mismatch_count(mismatch_count), .pairs_outstanding(pairs_outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: stretches of no stall, light, half and heavy stalling
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 80);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = 1'($urandom_range(0, 1));
      default: out_stall = ($urandom_range(0, 7) != 0);
    endcase
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_counts(logic layout, logic chip,
                             logic [9:0] a, logic [9:0] b, logic [9:0] c, logic [9:0] d);
    in_valid        = 1'b1;
    in_layout       = layout;
    in_target_chip  = chip;
    in_first_value  = a;
    in_second_value = b;
    in_third_value  = c;
    in_fourth_value = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [9:0] pick_count();
    logic [9:0] v;
    case ($urandom_range(0, 9)) inside
      [0:4]: v = 10'($urandom_range(0, 1023));
      [5:6]: v = 10'($urandom_range(0, 9));
      7:     v = 10'($urandom_range(0, 120));
      8: begin
        case ($urandom_range(0, 6))
          0: v = 10'd9;
          1: v = 10'd10;
          2: v = 10'd99;
          3: v = 10'd100;
          4: v = 10'd999;
          5: v = 10'd1000;
          default: v = 10'd1023;
        endcase
      end
      default: v = 10'($urandom_range(990, 1023));
    endcase
    return v;
  endfunction

  initial begin
    int sent;
    int burst;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // zeros, saturation and field boundaries for both layouts
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0);
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b0, 10'd999, 10'd1000, 10'd998, 10'd123);
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b1, 10'd100, 10'd99, 10'd10, 10'd9);
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b0, 10'd123, 10'd456, 10'd789, 10'd0);
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b1, 10'h155, 10'h2AA, 10'd512, 10'd1);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b0, 10'd99, 10'd100, 10'd9, 10'd10);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b1, 10'd98, 10'd76, 10'd54, 10'd3);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b0, 10'd12, 10'd34, 10'd56, 10'd7);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b1, 10'd10, 10'd1, 10'd0, 10'd9);
    send_counts(ssfb_pkg::LAYOUT_TWO, 1'b0, 10'd999, 10'h2AA, 10'h155, 10'd8);
    send_counts(ssfb_pkg::LAYOUT_THREE, 1'b0, 10'd888, 10'd111, 10'd555, 10'd246);

    sent = 0;
    while (sent < RANDOM_FRAMES) begin
      burst = $urandom_range(1, 10);
      for (int i = 0; i < burst && sent < RANDOM_FRAMES; i++) begin
        send_counts($urandom_range(0, 1) ? ssfb_pkg::LAYOUT_TWO : ssfb_pkg::LAYOUT_THREE,
                    1'($urandom_range(0, 1)),
                    pick_count(), pick_count(), pick_count(), pick_count());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_valid = 1'b0;

    while (pairs_outstanding != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("seven_segment_frame_builder_unit: match");
    end else begin
      $display("seven_segment_frame_builder_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("seven_segment_frame_builder_unit: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
